>>> hdl/ltwe_pkg.sv
// ============================================================================
// ltwe_pkg - shared types and constants of the line tokenizer
// Result record and queue entry layouts, character codes, result kinds and
// the C escape mapping used by the front end.
// ============================================================================
package ltwe_pkg;

	// Result kinds carried on the output tuser.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;

	// Character codes the parser reacts to.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// One result word, without the last marker.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       token_type;
		logic [3:0] token_index;
		logic [6:0] token_length;
		logic [4:0] token_count;
		logic       token_truncated;
		logic       count_overflow;
	} ltwe_rec_t;

	// What one input byte leaves for the back end: an optional token byte or
	// token end, followed by an optional line end.
	typedef struct packed {
		logic      has_tok;
		ltwe_rec_t tok;
		logic      has_line;
		ltwe_rec_t line;
	} ltwe_entry_t;

	// C escape letters map to control codes; anything else stands for itself.
	function automatic logic [7:0] map_escape(input logic [7:0] c);
		logic [7:0] r;
		begin
			case (c)
				8'h61:   r = 8'h07; // a
				8'h62:   r = 8'h08; // b
				8'h66:   r = 8'h0C; // f
				8'h6E:   r = 8'h0A; // n
				8'h72:   r = 8'h0D; // r
				8'h74:   r = 8'h09; // t
				8'h76:   r = 8'h0B; // v
				default: r = c;
			endcase
			return r;
		end
	endfunction

endpackage

>>> hdl/ltwe_front.sv
// ============================================================================
// ltwe_front - byte classifier and parse state of the line tokenizer
// Runs the per-byte parse state machine and builds the result records that
// each byte causes, as one queue entry for each byte that causes any.
// ============================================================================
module ltwe_front import ltwe_pkg::*; #(
	parameter int MAX_TOKEN_BYTES = 64,
	parameter int MAX_TOKENS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	output logic        push,
	output ltwe_entry_t entry
);

	localparam int LW = $clog2(MAX_TOKEN_BYTES + 1);
	localparam int SW = $clog2(MAX_TOKENS + 1);

	localparam logic [2:0] M_BETWEEN = 3'd0;
	localparam logic [2:0] M_WORD    = 3'd1;
	localparam logic [2:0] M_STRING  = 3'd2;
	localparam logic [2:0] M_ESCAPE  = 3'd3;
	localparam logic [2:0] M_SKIP    = 3'd4;
	localparam logic [2:0] M_DONE    = 3'd5;

	logic [2:0]    mode_q, mode_d;
	logic [LW-1:0] len_q;
	logic [SW-1:0] seen_q;
	logic          str_q, trunc_q, ovf_q;

	logic          ev_add, ev_tok, ev_line, ev_begin, begin_str;
	logic [7:0]    add_byte;
	logic          is_sep, is_stop, drop, room, add_ok, tok_ok;
	logic [LW-1:0] len_e, len_inc;
	logic [SW-1:0] seen_tok;
	logic          str_e, trunc_e, ovf_e;

	assign is_sep  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_COMMA);
	assign is_stop = (in_byte == CH_LF) || (in_byte == CH_CR) || (in_byte == CH_SEMI);

	always_comb begin
		ev_add    = 1'b0;
		ev_tok    = 1'b0;
		ev_line   = 1'b0;
		ev_begin  = 1'b0;
		begin_str = 1'b0;
		add_byte  = in_byte;
		mode_d    = mode_q;
		case (mode_q)
			M_WORD: begin
				if (in_byte == CH_NUL) begin
					ev_tok = 1'b1; ev_line = 1'b1; mode_d = M_BETWEEN;
				end else if (in_byte == CH_LF || in_byte == CH_CR) begin
					ev_tok = 1'b1; ev_line = 1'b1; mode_d = M_DONE;
				end else if (is_sep) begin
					ev_tok = 1'b1; mode_d = M_BETWEEN;
				end else begin
					ev_add = 1'b1;
				end
			end
			M_STRING: begin
				if (in_byte == CH_NUL) begin
					ev_tok = 1'b1; ev_line = 1'b1; mode_d = M_BETWEEN;
				end else if (in_byte == CH_QUOTE) begin
					ev_tok = 1'b1; mode_d = M_SKIP;
				end else if (in_byte == CH_BSLASH) begin
					mode_d = M_ESCAPE;
				end else begin
					ev_add = 1'b1;
				end
			end
			M_ESCAPE: begin
				if (in_byte == CH_NUL) begin
					ev_tok = 1'b1; ev_line = 1'b1; mode_d = M_BETWEEN;
				end else begin
					ev_add = 1'b1; add_byte = map_escape(in_byte); mode_d = M_STRING;
				end
			end
			M_DONE: begin
				if (in_byte == CH_NUL) mode_d = M_BETWEEN;
			end
			default: begin
				// Between tokens, or skipping stray bytes after a closing quote.
				if (in_byte == CH_NUL) begin
					ev_line = 1'b1; mode_d = M_BETWEEN;
				end else if (is_stop) begin
					ev_line = 1'b1; mode_d = M_DONE;
				end else if (is_sep) begin
					mode_d = M_BETWEEN;
				end else if (in_byte == CH_QUOTE) begin
					ev_begin = 1'b1; begin_str = 1'b1; mode_d = M_STRING;
				end else if (mode_q == M_SKIP) begin
					mode_d = M_SKIP;
				end else begin
					ev_begin = 1'b1; ev_add = 1'b1; mode_d = M_WORD;
				end
			end
		endcase
	end

	// A token that starts here sees fresh length and flags.
	assign drop    = (seen_q >= SW'(MAX_TOKENS));
	assign len_e   = ev_begin ? '0 : len_q;
	assign trunc_e = ev_begin ? 1'b0 : trunc_q;
	assign str_e   = ev_begin ? begin_str : str_q;
	assign ovf_e   = ovf_q | (ev_begin & drop);
	assign room    = (len_e < LW'(MAX_TOKEN_BYTES));
	assign len_inc = len_e + LW'(1);
	assign add_ok  = ev_add & ~drop & room;
	assign tok_ok  = ev_tok & ~drop;
	assign seen_tok = tok_ok ? seen_q + SW'(1) : seen_q;

	always_comb begin
		entry.has_tok               = add_ok | tok_ok;
		entry.tok.kind              = ev_tok ? KIND_END : KIND_BYTE;
		entry.tok.out_byte          = ev_tok ? 8'd0 : add_byte;
		entry.tok.token_type        = str_e;
		entry.tok.token_index       = 4'(seen_q);
		entry.tok.token_length      = ev_tok ? 7'(len_e) : 7'(len_inc);
		entry.tok.token_count       = 5'(seen_tok);
		entry.tok.token_truncated   = trunc_e;
		entry.tok.count_overflow    = ovf_e;
		entry.has_line              = ev_line;
		entry.line.kind             = KIND_LINE;
		entry.line.out_byte         = 8'd0;
		entry.line.token_type       = 1'b0;
		entry.line.token_index      = 4'd0;
		entry.line.token_length     = 7'd0;
		entry.line.token_count      = 5'(seen_tok);
		entry.line.token_truncated  = 1'b0;
		entry.line.count_overflow   = ovf_e;
	end

	assign push = accept & (entry.has_tok | entry.has_line);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_BETWEEN;
			len_q   <= '0;
			seen_q  <= '0;
			str_q   <= 1'b0;
			trunc_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			if (ev_line) begin
				len_q   <= '0;
				seen_q  <= '0;
				str_q   <= 1'b0;
				trunc_q <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				len_q   <= add_ok ? len_inc : len_e;
				seen_q  <= seen_tok;
				str_q   <= str_e;
				trunc_q <= trunc_e | (ev_add & ~drop & ~room);
				ovf_q   <= ovf_e;
			end
		end
	end

`ifndef SYNTH
	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SW'(MAX_TOKENS))
		else $error("token count above the line limit");
	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_TOKEN_BYTES))
		else $error("token length above the token limit");
`endif

endmodule

>>> hdl/ltwe_fifo.sv
// ============================================================================
// ltwe_fifo - short register queue between front and back end
// Holds per-byte entries so the classifier and the output side stall apart.
// ============================================================================
module ltwe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");
`endif

endmodule

>>> hdl/ltwe_back.sv
// ============================================================================
// ltwe_back - result sequencer of the line tokenizer
// Takes queue entries and sends their records out one word per cycle while the
// receiver takes them, through an output register with a one-record holding slot.
// ============================================================================
module ltwe_back import ltwe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ltwe_entry_t head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output ltwe_rec_t   out_rec,
	output logic        out_last
);

	logic      out_valid_q, out_last_q, pend_v_q, load;
	ltwe_rec_t out_rec_q, pend_rec_q;

	assign load = ~out_valid_q | out_ready;
	assign pop  = load & ~pend_v_q & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
		end else if (load) begin
			if (pend_v_q) begin
				out_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end else if (!empty) begin
				out_valid_q <= 1'b1;
				pend_v_q    <= head.has_tok & head.has_line;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_v_q) begin
				out_rec_q  <= pend_rec_q;
				out_last_q <= 1'b1;
			end else if (head.has_tok) begin
				out_rec_q  <= head.tok;
				out_last_q <= ~head.has_line;
				pend_rec_q <= head.line;
			end else begin
				out_rec_q  <= head.line;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;

`ifndef SYNTH
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> out_valid_q && !out_last_q)
		else $error("held line end without a word in front of it");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("entry taken from queue but no word presented");
`endif

endmodule

>>> hdl/line_tokenizer_with_escapes_core.sv
// ============================================================================
// line_tokenizer_with_escapes_core - assembler line tokenizer with C escapes
// Splits NUL-terminated lines, one byte per word, into tokens and sends
// token bytes, token ends and line ends as result words.
// ============================================================================
//
// Channel   Dir  Word contents (tdata low bit first)              Marks
// s_axis    in   [7:0] in_byte                                  -
// m_axis    out  [7:0] out_byte, [8] token_type,                tuser[1:0] kind,
//                [12:9] token_index, [19:13] token_length,      tlast = final
//                [24:20] token_count, [25] token_truncated,     word of a byte
//                [26] count_overflow, [31:27] zero
//
// One input byte is taken every cycle while the queue has room. The byte is
// classified and its records are written to the queue at the edge that accepts
// it, and the output register then loads the first record from the queue, where
// the first result word can be taken on m_axis. The output side sends one word
// per cycle while m_axis_tready is high, so a byte that ends both a token and a
// line takes two output words; the QUEUE_DEPTH-entry queue absorbs that and
// output stalls.
// s_axis_tready drops only when the queue is full. Reset is asynchronous and
// needs no start-up sweep: the block accepts bytes as soon as reset is released.
//
module line_tokenizer_with_escapes_core import ltwe_pkg::*; #(
	parameter int MAX_TOKEN_BYTES = 64,
	parameter int MAX_TOKENS      = 16,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // out_byte, token_type, token_index,
	                                    // token_length, token_count,
	                                    // token_truncated, count_overflow, pad
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);

	logic        accept, push, pop, q_full, q_empty;
	ltwe_entry_t entry, head;
	ltwe_rec_t   out_rec;

	assign s_axis_tready = ~q_full;
	assign accept        = s_axis_tvalid & s_axis_tready;

	// Front end: parse state and record building for each accepted byte.
	ltwe_front #(
		.MAX_TOKEN_BYTES (MAX_TOKEN_BYTES),
		.MAX_TOKENS      (MAX_TOKENS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_axis_tdata),
		.push    (push),
		.entry   (entry)
	);

	// Queue: bytes that cause no result are never written.
	ltwe_fifo #(
		.WIDTH ($bits(ltwe_entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end: one result word per cycle into the output register while m_axis_tready is high.
	ltwe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rec   (out_rec),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tuser = out_rec.kind;
	assign m_axis_tdata = {5'd0, out_rec.count_overflow, out_rec.token_truncated,
		out_rec.token_count, out_rec.token_length, out_rec.token_index,
		out_rec.token_type, out_rec.out_byte};

endmodule

>>> dv/line_tokenizer_with_escapes_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// line_tokenizer_with_escapes_core_test - self-checking bench for the tokenizer
// Feeds NUL-terminated lines into the byte stream with random gaps, predicts
// every token byte, token end and line end in a scoreboard, and compares each
// word leaving the block field by field while the output side stalls at random.
// ============================================================================
module line_tokenizer_with_escapes_core_test;
	import ltwe_pkg::*;

	localparam int TOKEN_BYTES_MAX = 64;
	localparam int TOKENS_MAX      = 16;
	localparam int RANDOM_BYTES    = 1150;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 100;

	localparam logic [7:0] SEPARATORS [3] = '{CH_SPACE, CH_TAB, CH_COMMA};
	// Letters that have a meaning after a backslash, plus the single and double quote,
	// question mark and backslash that stand for themselves.
	localparam logic [7:0] ESCAPE_LETTERS [11] = '{8'h27, 8'h22, 8'h3F, 8'h5C, 8'h61,
		8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76};

	// Opening lines: a word holding ';', '"' and 0xFF ended by a space, a string
	// with escapes, a stray byte after the closing quote, a string opened from
	// that skip state and cut by NUL right after a backslash; then a word ended
	// by LF with ignored bytes behind it, a ';' that ends an empty line, and a
	// word ended by NUL.
	localparam logic [7:0] OPENING_BYTES [27] = '{
		8'h01, 8'h3B, 8'h22, 8'hFF, 8'h20,
		8'h22, 8'h5C, 8'h6E, 8'h5C, 8'h7A, 8'h5C, 8'h22, 8'h22,
		8'h71, 8'h22, 8'h5C, 8'h00,
		8'h2C, 8'h6B, 8'h0A, 8'h78, 8'h00,
		8'h09, 8'h3B, 8'h00,
		8'h7E, 8'h00};

	typedef enum logic [2:0] {
		MODE_BETWEEN, MODE_WORD, MODE_STRING, MODE_ESCAPE, MODE_SKIP, MODE_DONE
	} parse_mode_t;

	typedef enum int {LINE_LONG, LINE_CROWDED, LINE_NOISE, LINE_PLAIN} line_shape_t;

	typedef struct packed {
		ltwe_rec_t rec;
		logic      last;
	} result_word_t;

	// Tracks the parser state of the block and holds the words it must send.
	class tokenizer_scoreboard;
		parse_mode_t    mode;
		int unsigned    tok_len;
		int unsigned    tok_count;
		logic           in_string;
		logic           truncated;
		logic           overflowed;
		result_word_t   expected_words[$];
		int unsigned    mismatches;
		int unsigned    words_checked;
		int unsigned    token_ends;
		int unsigned    truncated_ends;
		int unsigned    line_ends;
		int unsigned    overflow_lines;

		function new();
			mode = MODE_BETWEEN;
			clear_line();
		endfunction

		function void clear_line();
			tok_count = 0;
			overflowed = 1'b0;
			tok_len = 0;
			truncated = 1'b0;
			in_string = 1'b0;
		endfunction

		function void push_word(logic [1:0] kind, logic [7:0] b, logic tok_type,
				int unsigned idx, int unsigned len, int unsigned cnt, logic trunc);
			result_word_t w;
			w.rec.kind = kind;
			w.rec.out_byte = b;
			w.rec.token_type = tok_type;
			w.rec.token_index = 4'(idx);
			w.rec.token_length = 7'(len);
			w.rec.token_count = 5'(cnt);
			w.rec.token_truncated = trunc;
			w.rec.count_overflow = overflowed;
			w.last = 1'b0;
			expected_words.push_back(w);
		endfunction

		function logic [7:0] unescape(logic [7:0] c);
			case (c)
				8'h61: return 8'h07;
				8'h62: return 8'h08;
				8'h66: return 8'h0C;
				8'h6E: return 8'h0A;
				8'h72: return 8'h0D;
				8'h74: return 8'h09;
				8'h76: return 8'h0B;
				default: return c;
			endcase
		endfunction

		// Once the line holds the maximum number of tokens, further tokens are
		// parsed but leave no trace except the overflow flag.
		function void start_token(logic quoted);
			tok_len = 0;
			truncated = 1'b0;
			in_string = quoted;
			if (tok_count >= TOKENS_MAX)
				overflowed = 1'b1;
		endfunction

		function void keep_byte(logic [7:0] c);
			if (tok_count >= TOKENS_MAX)
				return;
			if (tok_len >= TOKEN_BYTES_MAX) begin
				truncated = 1'b1;
				return;
			end
			tok_len++;
			push_word(KIND_BYTE, c, in_string, tok_count, tok_len, tok_count, truncated);
		endfunction

		function void close_token();
			if (tok_count >= TOKENS_MAX)
				return;
			tok_count++;
			push_word(KIND_END, 8'h00, in_string, tok_count - 1, tok_len, tok_count, truncated);
		endfunction

		function void close_line();
			push_word(KIND_LINE, 8'h00, 1'b0, 0, 0, tok_count, 1'b0);
			clear_line();
		endfunction

		// Works out the words caused by one accepted input byte.
		function void note_input_byte(logic [7:0] c);
			int unsigned queued;
			queued = expected_words.size();
			case (mode)
				MODE_WORD: begin
					if (c == CH_NUL) begin
						close_token();
						close_line();
						mode = MODE_BETWEEN;
					end else if (c == CH_LF || c == CH_CR) begin
						close_token();
						close_line();
						mode = MODE_DONE;
					end else if (c inside {CH_SPACE, CH_TAB, CH_COMMA}) begin
						close_token();
						mode = MODE_BETWEEN;
					end else begin
						keep_byte(c);
					end
				end
				MODE_STRING: begin
					if (c == CH_NUL) begin
						close_token();
						close_line();
						mode = MODE_BETWEEN;
					end else if (c == CH_QUOTE) begin
						close_token();
						mode = MODE_SKIP;
					end else if (c == CH_BSLASH) begin
						mode = MODE_ESCAPE;
					end else begin
						keep_byte(c);
					end
				end
				MODE_ESCAPE: begin
					if (c == CH_NUL) begin
						close_token();
						close_line();
						mode = MODE_BETWEEN;
					end else begin
						keep_byte(unescape(c));
						mode = MODE_STRING;
					end
				end
				MODE_DONE: begin
					if (c == CH_NUL)
						mode = MODE_BETWEEN;
				end
				default: begin
					if (c == CH_NUL) begin
						close_line();
						mode = MODE_BETWEEN;
					end else if (c inside {CH_LF, CH_CR, CH_SEMI}) begin
						close_line();
						mode = MODE_DONE;
					end else if (c inside {CH_SPACE, CH_TAB, CH_COMMA}) begin
						mode = MODE_BETWEEN;
					end else if (c == CH_QUOTE) begin
						start_token(1'b1);
						mode = MODE_STRING;
					end else if (mode == MODE_BETWEEN) begin
						start_token(1'b0);
						keep_byte(c);
						mode = MODE_WORD;
					end
				end
			endcase
			if (expected_words.size() > queued)
				expected_words[expected_words.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] result word %0d: %s", $time, words_checked, what);
		endtask

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_result_word(ltwe_rec_t got, logic got_last);
			result_word_t want;
			words_checked++;
			if (expected_words.size() == 0) begin
				report_mismatch("word arrived with nothing expected");
				return;
			end
			want = expected_words.pop_front();
			check_field("kind", 8'(got.kind), 8'(want.rec.kind));
			check_field("out_byte", got.out_byte, want.rec.out_byte);
			check_field("token_type", 8'(got.token_type), 8'(want.rec.token_type));
			check_field("token_index", 8'(got.token_index), 8'(want.rec.token_index));
			check_field("token_length", 8'(got.token_length), 8'(want.rec.token_length));
			check_field("token_count", 8'(got.token_count), 8'(want.rec.token_count));
			check_field("token_truncated", 8'(got.token_truncated),
				8'(want.rec.token_truncated));
			check_field("count_overflow", 8'(got.count_overflow), 8'(want.rec.count_overflow));
			check_field("last", 8'(got_last), 8'(want.last));
			if (want.rec.kind == KIND_END) begin
				token_ends++;
				if (want.rec.token_truncated)
					truncated_ends++;
			end else if (want.rec.kind == KIND_LINE) begin
				line_ends++;
				if (want.rec.count_overflow)
					overflow_lines++;
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	tokenizer_scoreboard sb = new();
	int send_calm = 0;
	int recv_calm = 0;
	int idle_cycles = 0;
	int bytes_sent = 0;
	int lines_sent = 0;

	line_tokenizer_with_escapes_core #(
		.MAX_TOKEN_BYTES(TOKEN_BYTES_MAX),
		.MAX_TOKENS(TOKENS_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Random gaps between words, broken now and then by a run of back-to-back words.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [7:0] word_char(bit leading);
		logic [7:0] c;
		do begin
			c = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(33, 126))
			                                 : 8'($urandom_range(1, 255));
		end while (c inside {CH_SPACE, CH_TAB, CH_COMMA, CH_LF, CH_CR} ||
			(leading && c inside {CH_QUOTE, CH_SEMI}));
		return c;
	endfunction

	function automatic logic [7:0] string_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(1, 255));
		end while (c inside {CH_QUOTE, CH_BSLASH});
		return c;
	endfunction

	task automatic send_byte(logic [7:0] c);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Builds one line of the given shape and sends it. Bytes that the block
	// ignores after an early line end are left out of the byte count.
	task automatic send_line(line_shape_t shape);
		logic [7:0] line[$];
		int n_tok;
		int min_len;
		int max_len;
		int len;
		int ignored;
		int ending;
		bit quoted;
		bit open_end;
		ignored = 0;
		open_end = 1'b0;
		case (shape)
			LINE_LONG: begin
				n_tok = $urandom_range(1, 2);
				min_len = 60;
				max_len = 80;
			end
			LINE_CROWDED: begin
				n_tok = $urandom_range(15, 20);
				min_len = 1;
				max_len = 3;
			end
			LINE_NOISE: begin
				n_tok = 0;
				min_len = 1;
				max_len = 1;
				repeat ($urandom_range(1, 12)) line.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				n_tok = $urandom_range(0, 6);
				min_len = 1;
				max_len = 10;
			end
		endcase
		for (int t = 0; t < n_tok; t++) begin
			if (t > 0 || $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) line.push_back(SEPARATORS[$urandom_range(0, 2)]);
			len = $urandom_range(min_len, max_len);
			quoted = ($urandom_range(0, 2) == 0);
			if (quoted) begin
				line.push_back(CH_QUOTE);
				repeat (len) begin
					if ($urandom_range(0, 3) == 0) begin
						line.push_back(CH_BSLASH);
						line.push_back(($urandom_range(0, 3) != 0)
							? ESCAPE_LETTERS[$urandom_range(0, 10)]
							: 8'($urandom_range(1, 255)));
					end else begin
						line.push_back(string_char());
					end
				end
				// Now and then the last string is left open, sometimes right
				// after a backslash, so that NUL has to close it.
				if (t == n_tok - 1 && $urandom_range(0, 4) == 0) begin
					open_end = 1'b1;
					if ($urandom_range(0, 1) != 0)
						line.push_back(CH_BSLASH);
				end else begin
					line.push_back(CH_QUOTE);
					if ($urandom_range(0, 5) == 0)
						line.push_back(word_char(1'b0));
				end
			end else begin
				line.push_back(word_char(1'b1));
				repeat (len - 1) line.push_back(word_char(1'b0));
			end
		end
		if (!open_end && shape != LINE_NOISE) begin
			ending = $urandom_range(0, 5);
			if (ending == 3 || ending == 5)
				line.push_back(SEPARATORS[$urandom_range(0, 2)]);
			if (ending == 4)
				line.push_back(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
			if (ending == 5)
				line.push_back(CH_SEMI);
			if (ending >= 4) begin
				ignored = $urandom_range(0, 4);
				repeat (ignored) line.push_back(8'($urandom_range(1, 255)));
				ignored++;
			end
		end
		line.push_back(CH_NUL);
		foreach (line[i]) send_byte(line[i]);
		bytes_sent += line.size() - ignored;
		lines_sent++;
	endtask

	// Output side: stalls for a random number of cycles, then takes one word.
	initial begin : result_sink
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : word_monitor
		ltwe_rec_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.out_byte = m_axis_tdata[7:0];
				got.token_type = m_axis_tdata[8];
				got.token_index = m_axis_tdata[12:9];
				got.token_length = m_axis_tdata[19:13];
				got.token_count = m_axis_tdata[24:20];
				got.token_truncated = m_axis_tdata[25];
				got.count_overflow = m_axis_tdata[26];
				sb.check_result_word(got, m_axis_tlast);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("No word moved for %0d cycles, run stopped.", WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int line_no;
		line_shape_t shape;
		int pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
		bytes_sent += $size(OPENING_BYTES);

		// The first two random lines are shaped toward the token length and token count
		// limits; after that the shape is drawn per line.
		line_no = 0;
		while (bytes_sent < RANDOM_BYTES + $size(OPENING_BYTES)) begin
			pick = $urandom_range(0, 19);
			if (line_no < 2)
				shape = line_shape_t'(line_no);
			else if (pick < 2)
				shape = LINE_LONG;
			else if (pick < 4)
				shape = LINE_CROWDED;
			else if (pick < 6)
				shape = LINE_NOISE;
			else
				shape = LINE_PLAIN;
			send_line(shape);
			line_no++;
		end
		s_axis_tvalid <= 1'b0;

		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d counted bytes in %0d random lines; checked %0d result words.",
			bytes_sent, lines_sent, sb.words_checked);
		$display("Seen %0d token ends (%0d cut short) and %0d line ends (%0d over the token limit).",
			sb.token_ends, sb.truncated_ends, sb.line_ends, sb.overflow_lines);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> line_tokenizer_with_escapes_core.f
hdl/ltwe_pkg.sv
hdl/ltwe_front.sv
hdl/ltwe_fifo.sv
hdl/ltwe_back.sv
hdl/line_tokenizer_with_escapes_core.sv
dv/line_tokenizer_with_escapes_core_test.sv
